@@ src/indexed_list_insert_remove_defines.svh @@
// ----------------------------------------------------------------------------
// indexed list assertion macros
// shared property templates for the positional list block
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ILIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ILIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ilir_pkg.sv @@
// ----------------------------------------------------------------------------
// ilir_pkg
// sizes, operation and status codes of the positional list
// ----------------------------------------------------------------------------
package ilir_pkg;

    // list geometry
    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;

    // fixed port field widths
    localparam int OP_W   = 2;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    // derived widths
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WIDE_W = (ELEM_WIDTH > DATA_W) ? ELEM_WIDTH : DATA_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_GET    = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_GET   = 6'b000010,
        S_UP    = 6'b000100,
        S_PUT   = 6'b001000,
        S_RM1   = 6'b010000,
        S_DN    = 6'b100000
    } state_t;

endpackage

@@ src/ilir_ram.sv @@
// ----------------------------------------------------------------------------
// ilir_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ilir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ src/indexed_list_insert_remove.sv @@
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// positional list with get, set, insert and remove over one element ram
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows
// on status, element_out and count_after for exactly one cycle with done
// high, and the receiver cannot stall it. Elements live in a single ram
// with one write and one registered read port, so a shift moves one
// element per cycle. The ram contents are not cleared at reset. Set,
// append and failed requests answer from idle; get reads in S_GET;
// insert shifts up in S_UP, then writes in S_PUT; remove shifts down
// in S_RM1 and S_DN. done rises in the cycle after the last state.
`include "indexed_list_insert_remove_defines.svh"

module indexed_list_insert_remove (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ilir_pkg::OP_W-1:0]     operation,
    input  logic [ilir_pkg::POS_W-1:0]    position,
    input  logic [ilir_pkg::DATA_W-1:0]   element_in,
    output logic                          done,
    output logic [ilir_pkg::STAT_W-1:0]   status,
    output logic [ilir_pkg::DATA_W-1:0]   element_out,
    output logic [ilir_pkg::POS_W-1:0]    count_after
);

    import ilir_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     ptr_reg, ptr_next;
    logic [ADDR_W-1:0]     pos_reg, pos_next;
    logic [ELEM_WIDTH-1:0] val_reg, val_next;
    logic                  done_reg, done_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [ELEM_WIDTH-1:0] elem_reg, elem_next;

    logic                  accept;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic [ADDR_W-1:0]     pos_a;
    logic [CNT_W-1:0]      cnt_m1;
    logic [ADDR_W-1:0]     last_a;
    logic [WIDE_W-1:0]     in_wide;
    logic [ELEM_WIDTH-1:0] in_elem;
    logic [WIDE_W-1:0]     out_wide;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ELEM_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ELEM_WIDTH-1:0] ram_rdata;

    // request decode helpers
    assign accept  = start && (state_reg == S_IDLE);
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_a   = pos_ext[ADDR_W-1:0];
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign last_a  = cnt_m1[ADDR_W-1:0];
    assign in_wide = WIDE_W'(element_in);
    assign in_elem = in_wide[ELEM_WIDTH-1:0];

    // element storage
    ilir_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer: one ram read and at most one ram write per cycle
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        elem_next   = elem_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = val_reg;
        ram_raddr   = pos_a;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next  = pos_a;
                    val_next  = in_elem;
                    elem_next = '0;
                    if (operation == OP_INSERT)
                    begin
                        if (pos_ext > cnt_ext)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_BAD_INDEX;
                        end
                        else if (count_reg == CNT_W'(CAPACITY))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                        end
                        else if (pos_ext == cnt_ext)
                        begin
                            // append, nothing to shift
                            ram_we      = 1'b1;
                            ram_waddr   = pos_a;
                            ram_wdata   = in_elem;
                            count_next  = count_reg + CNT_W'(1);
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                        else
                        begin
                            // start shifting up from the last element
                            ram_raddr  = last_a;
                            ptr_next   = last_a;
                            state_next = S_UP;
                        end
                    end
                    else if (pos_ext >= cnt_ext)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_BAD_INDEX;
                    end
                    else if (operation == OP_SET)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = pos_a;
                        ram_wdata   = in_elem;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                    end
                    else if (operation == OP_GET)
                    begin
                        ram_raddr  = pos_a;
                        state_next = S_GET;
                    end
                    else
                    begin
                        ram_raddr  = pos_a;
                        ptr_next   = pos_a;
                        state_next = S_RM1;
                    end
                end
            end

            S_GET:
            begin
                elem_next   = ram_rdata;
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end

            S_UP:
            begin
                // element read last cycle moves one slot up
                ram_we    = 1'b1;
                ram_waddr = ptr_reg + ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (ptr_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_raddr = ptr_reg - ADDR_W'(1);
                    ptr_next  = ptr_reg - ADDR_W'(1);
                end
            end

            S_PUT:
            begin
                ram_we      = 1'b1;
                ram_waddr   = pos_reg;
                ram_wdata   = val_reg;
                count_next  = count_reg + CNT_W'(1);
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end

            S_RM1:
            begin
                // capture the removed element
                elem_next = ram_rdata;
                if (ptr_reg == last_a)
                begin
                    count_next  = cnt_m1;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_raddr  = ptr_reg + ADDR_W'(1);
                    ptr_next   = ptr_reg + ADDR_W'(1);
                    state_next = S_DN;
                end
            end

            S_DN:
            begin
                // element read last cycle moves one slot down
                ram_we    = 1'b1;
                ram_waddr = ptr_reg - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (ptr_reg == last_a)
                begin
                    count_next  = cnt_m1;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_raddr = ptr_reg + ADDR_W'(1);
                    ptr_next  = ptr_reg + ADDR_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // request and result payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        elem_reg   <= elem_next;
    end

    // outputs
    assign out_wide    = WIDE_W'(elem_reg);
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign element_out = out_wide[DATA_W-1:0];
    assign count_after = cnt_ext[POS_W-1:0];

    // checks
    `ILIR_ASSERT_IMP(a_done_idle, done_reg, state_reg == S_IDLE,
        "result strobe while sequencer busy")
    `ILIR_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "element count above capacity")
    `ILIR_ASSERT_IMP(a_full_status, done_reg && (status_reg == ST_FULL),
        count_reg == CNT_W'(CAPACITY), "full status with room left")
    `ILIR_ASSERT_IMP(a_up_range, state_reg == S_UP,
        (ptr_reg >= pos_reg) && (CNT_W'(ptr_reg) < count_reg),
        "shift-up pointer out of range")
    `ILIR_ASSERT_NXT(a_get_path,
        accept && (operation == OP_GET) && (pos_ext < cnt_ext),
        state_reg == S_GET, "valid get did not issue a read")

endmodule

@@ dv/indexed_list_insert_remove_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_tb
// self-checking bench for the positional list: a directed pass over the
// empty, full and out-of-range corners, then random request streams that
// grow and shrink the list, each response checked against a shadow list
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_tb;

    import ilir_pkg::*;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_REQUESTS = 1200;
    localparam int CHUNK_REQUESTS  = 150;
    localparam int IDLE_PERCENT    = 11;
    localparam int QUIET_FIRST     = 400;
    localparam int QUIET_LAST      = 700;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] data;
    } list_request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] element;
        logic [POS_W-1:0]  count;
    } list_result_t;

    // dut signals, all inputs known from time zero
    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic [OP_W-1:0]   operation  = '0;
    logic [POS_W-1:0]  position   = '0;
    logic [DATA_W-1:0] element_in = '0;
    logic              busy;
    logic              done;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] element_out;
    logic [POS_W-1:0]  count_after;

    // request and response bookkeeping
    list_request_t pending_requests [$];
    list_result_t  expected_results [$];
    logic          accept_seen = 1'b0;
    int            issued_count = 0;
    int            planned_count = 0;
    int            fail_count = 0;
    int            cycle_count = 0;

    // shadow list used for prediction
    logic [ELEM_WIDTH-1:0] held_slots [CAPACITY];
    int                    held_count = 0;
    int                    deepest_count = 0;
    int                    op_seen [4] = '{0, 0, 0, 0};
    int                    status_seen [3] = '{0, 0, 0};

    indexed_list_insert_remove uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .position    (position),
        .element_in  (element_in),
        .done        (done),
        .status      (status),
        .element_out (element_out),
        .count_after (count_after)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // predict one request against the shadow list and update it
    function automatic list_result_t apply_request(list_request_t r);
        list_result_t res;
        int           p;
        p = int'(r.pos);
        res.status  = ST_OK;
        res.element = '0;
        op_seen[r.op]++;
        if (r.op == OP_INSERT)
        begin
            if (p > held_count)
                res.status = ST_BAD_INDEX;
            else if (held_count >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                for (int i = held_count; i > p; i--)
                    held_slots[i] = held_slots[i-1];
                held_slots[p] = r.data[ELEM_WIDTH-1:0];
                held_count++;
            end
        end
        else if (p >= held_count)
            res.status = ST_BAD_INDEX;
        else if (r.op == OP_GET)
            res.element = DATA_W'(held_slots[p]);
        else if (r.op == OP_SET)
            held_slots[p] = r.data[ELEM_WIDTH-1:0];
        else
        begin
            // remove closes the gap by shifting later elements down
            res.element = DATA_W'(held_slots[p]);
            for (int i = p; i + 1 < held_count; i++)
                held_slots[i] = held_slots[i+1];
            held_count--;
        end
        if (held_count > deepest_count)
            deepest_count = held_count;
        res.count = POS_W'(held_count);
        return res;
    endfunction

    // queue a request and track the list depth it leads to
    task automatic queue_request(input logic [OP_W-1:0] op, input int pos,
                                 input logic [DATA_W-1:0] data);
        list_request_t r;
        r.op   = op;
        r.pos  = POS_W'(pos);
        r.data = data;
        pending_requests.push_back(r);
        if (op == OP_INSERT && pos <= planned_count && planned_count < CAPACITY)
            planned_count++;
        else if (op == OP_REMOVE && pos < planned_count)
            planned_count--;
    endtask

    // random requests, biased toward growing or shrinking the list
    task automatic queue_random_chunk(input int n, input bit grow);
        logic [OP_W-1:0] op;
        int              roll;
        int              top;
        int              pos;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (grow)
                op = (roll < 50) ? OP_INSERT : (roll < 65) ? OP_REMOVE :
                     (roll < 85) ? OP_GET : OP_SET;
            else
                op = (roll < 20) ? OP_INSERT : (roll < 60) ? OP_REMOVE :
                     (roll < 80) ? OP_GET : OP_SET;
            top = (op == OP_INSERT) ? planned_count : planned_count - 1;
            if (top < 0 || $urandom_range(0, 99) < 12)
                pos = $urandom_range(top + 1, 31);
            else
                pos = $urandom_range(0, top);
            queue_request(op, pos, $urandom);
        end
    endtask

    // hold off until every queued request has been answered
    task automatic wait_drained();
        while (pending_requests.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // driver: present requests at the falling edge, hold until accepted
    always @(negedge clk)
    begin : request_driver
        list_request_t r;
        bit            quiet;
        quiet = issued_count >= QUIET_FIRST && issued_count < QUIET_LAST;
        if (!rst_n)
            start <= 1'b0;
        else if (start && !accept_seen)
            start <= 1'b1;
        else if (pending_requests.size() != 0 &&
                 (quiet || $urandom_range(0, 99) >= IDLE_PERCENT))
        begin
            r = pending_requests.pop_front();
            start      <= 1'b1;
            operation  <= r.op;
            position   <= r.pos;
            element_in <= r.data;
            issued_count++;
        end
        else
        begin
            // idle cycle, fields carry noise the block must ignore
            start      <= 1'b0;
            operation  <= OP_W'($urandom_range(0, 3));
            position   <= POS_W'($urandom_range(0, 31));
            element_in <= $urandom;
        end
    end

    // monitor: check responses, then predict any request taken this edge
    always @(posedge clk)
    begin : response_monitor
        list_result_t  want;
        list_request_t r;
        if (!rst_n)
            accept_seen <= 1'b0;
        else
        begin
            if (done)
            begin
                if (status < 3)
                    status_seen[status]++;
                if (expected_results.size() == 0)
                begin
                    $error("response with none outstanding: status %0d element %h count %0d",
                           status, element_out, count_after);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (element_out !== want.element)
                    begin
                        $error("element_out: expected %h, got %h", want.element, element_out);
                        fail_count++;
                    end
                    if (count_after !== want.count)
                    begin
                        $error("count_after: expected %0d, got %0d", want.count, count_after);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                r.op   = operation;
                r.pos  = position;
                r.data = element_in;
                expected_results.push_back(apply_request(r));
            end
            accept_seen <= start && !busy;
        end
    end

    // timeout
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $error("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

    // stimulus sequence
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list: every access is out of range, insert past the end too
        queue_request(OP_GET, 0, 32'h0000_0000);
        queue_request(OP_REMOVE, 0, 32'h0000_0000);
        queue_request(OP_SET, 0, 32'hFFFF_FFFF);
        queue_request(OP_INSERT, 1, 32'hFFFF_FFFF);
        // append into empty, insert at the front and in the middle
        queue_request(OP_INSERT, 0, 32'hFFFF_FFFF);
        queue_request(OP_INSERT, 0, 32'h0000_0000);
        queue_request(OP_INSERT, 1, 32'hA5A5_A5A5);
        queue_request(OP_GET, 2, 32'h0000_0000);
        queue_request(OP_SET, 0, 32'h5A5A_5A5A);
        queue_request(OP_GET, 3, 32'h0000_0000);
        queue_request(OP_GET, 31, 32'h0000_0000);
        // append until the list is full
        while (planned_count < CAPACITY)
            queue_request(OP_INSERT, planned_count, $urandom);
        // full list: append and front insert refused, index checked first
        queue_request(OP_INSERT, CAPACITY, 32'h1234_5678);
        queue_request(OP_INSERT, 0, 32'h1234_5678);
        queue_request(OP_INSERT, CAPACITY + 1, 32'h1234_5678);
        queue_request(OP_GET, CAPACITY - 1, 32'h0000_0000);
        // remove the last element, then the first, then one out of range
        queue_request(OP_REMOVE, CAPACITY - 1, 32'h0000_0000);
        queue_request(OP_REMOVE, 0, 32'h0000_0000);
        queue_request(OP_REMOVE, 31, 32'h0000_0000);

        // sender stays quiet until the directed responses are all back
        wait_drained();

        for (int c = 0; c * CHUNK_REQUESTS < RANDOM_REQUESTS; c++)
        begin
            queue_random_chunk(CHUNK_REQUESTS, c % 2 == 0);
            if (c == 3)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests: get %0d, set %0d, insert %0d, remove %0d",
                 issued_count, op_seen[OP_GET], op_seen[OP_SET],
                 op_seen[OP_INSERT], op_seen[OP_REMOVE]);
        $display("responses ok %0d, bad index %0d, full %0d; list reached %0d elements",
                 status_seen[ST_OK], status_seen[ST_BAD_INDEX], status_seen[ST_FULL],
                 deepest_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
